@@ rtl/gtf_pkg.sv @@
// gtf_pkg: shared types, codes and default sizes of the team queue.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gtf_pkg;

	// default sizes, handed to the top level parameters
	localparam int TEAMS_DEF        = 256;
	localparam int TEAM_DEPTH_DEF   = 256;
	localparam int ELEMENT_BITS_DEF = 24;

	// fixed widths of the request and result fields
	localparam int ELEM_W   = 24;
	localparam int TEAM_W   = 8;
	localparam int STATUS_W = 2;

	// request operation codes
	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// which result the output register takes
	typedef enum logic [1:0] {
		OUT_OK,
		OUT_EMPTY,
		OUT_FULL,
		OUT_DATA
	} out_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     clear_step;
		logic     capture;
		logic     ord_rd;
		logic     team_rd_ord;
		logic     enq_commit;
		logic     deq_commit;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic order_empty;
		logic team_full;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/gtf_ctrl.sv @@
// gtf_ctrl: sequencing state machine of the team queue.
// Issues commands to gtf_dp and reads its status; uses gtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtf_ctrl
	import gtf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire logic kind,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EQ_TEAM,
		S_DQ_ORD,
		S_DQ_TEAM,
		S_DQ_ELEM,
		S_DQ_NONE
	} state_t;

	state_t state_q;
	state_t state_d;

	// requests are taken only between operations
	assign req_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					unique case (kind_t'(kind))
						KIND_ENQ: begin
							cmd.capture = 1'b1;
							state_d     = S_EQ_TEAM;
						end
						KIND_DEQ: begin
							if (sts.order_empty) begin
								state_d = S_DQ_NONE;
							end else begin
								cmd.ord_rd = 1'b1;
								state_d    = S_DQ_ORD;
							end
						end
					endcase
				end
			end
			S_EQ_TEAM: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.team_full) begin
						cmd.out_sel = OUT_FULL;
					end else begin
						cmd.enq_commit = 1'b1;
						cmd.out_sel    = OUT_OK;
					end
					state_d = S_IDLE;
				end
			end
			S_DQ_ORD: begin
				cmd.team_rd_ord = 1'b1;
				state_d         = S_DQ_TEAM;
			end
			S_DQ_TEAM: begin
				cmd.deq_commit = 1'b1;
				state_d        = S_DQ_ELEM;
			end
			S_DQ_ELEM: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_DATA;
					state_d      = S_IDLE;
				end
			end
			S_DQ_NONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_EMPTY;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/gtf_dp.sv @@
// gtf_dp: datapath of the team queue: element store, per-team pointer table,
// team order store, order pointers and result register. Uses gtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtf_dp
	import gtf_pkg::*;
#(
	parameter int TEAMS        = TEAMS_DEF,
	parameter int TEAM_DEPTH   = TEAM_DEPTH_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [ELEM_W-1:0] element,
	input  wire logic [TEAM_W-1:0] team,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [STATUS_W-1:0]    status,
	output logic                   has_data,
	output logic [ELEM_W-1:0]      element_out
);

	localparam int TW  = $clog2(TEAMS);
	localparam int DW  = $clog2(TEAM_DEPTH);
	localparam int CW  = $clog2(TEAM_DEPTH + 1);
	localparam int OCW = $clog2(TEAMS + 1);
	localparam int AW  = $clog2(TEAMS * TEAM_DEPTH);
	localparam int EB  = ELEMENT_BITS;

	typedef struct packed {
		logic [DW-1:0] head;
		logic [DW-1:0] tail;
		logic [CW-1:0] count;
	} team_ent_t;

	// storage
	logic [EB-1:0] elem_mem [TEAMS*TEAM_DEPTH];
	team_ent_t     tt_mem   [TEAMS];
	logic [TW-1:0] ord_mem  [TEAMS];

	// team number folding, one constant entry per team field code
	logic [TW-1:0] team_map [1<<TEAM_W];
	for (genvar g = 0; g < (1 << TEAM_W); g++) begin : g_map
		assign team_map[g] = TW'(g % TEAMS);
	end

	logic [TW-1:0]  clr_q;
	logic [TW-1:0]  team_q;
	logic [EB-1:0]  elem_q;
	team_ent_t      tt_rdata_q;
	logic [TW-1:0]  ord_rdata_q;
	logic [EB-1:0]  elem_rdata_q;
	logic [TW-1:0]  ord_head_q;
	logic [TW-1:0]  ord_tail_q;
	logic [OCW-1:0] ord_count_q;
	logic           out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic           has_data_q;
	logic [ELEM_W-1:0]   element_out_q;

	logic           tt_rd;
	logic [TW-1:0]  tt_raddr;
	logic           tt_we;
	logic [TW-1:0]  tt_waddr;
	team_ent_t      tt_wdata;
	logic [DW-1:0]  head_next;
	logic [DW-1:0]  tail_next;
	logic [DW-1:0]  slot;
	logic [AW-1:0]  elem_addr;
	logic           team_empty;
	logic           team_last;

	// per-team entry arithmetic
	assign head_next  = (tt_rdata_q.head == DW'(TEAM_DEPTH - 1)) ? '0 : tt_rdata_q.head + 1'b1;
	assign tail_next  = (tt_rdata_q.tail == DW'(TEAM_DEPTH - 1)) ? '0 : tt_rdata_q.tail + 1'b1;
	assign team_empty = (tt_rdata_q.count == '0);
	assign team_last  = (tt_rdata_q.count == CW'(1));

	// element slot address: team row plus slot
	assign slot      = cmd.enq_commit ? tt_rdata_q.tail : tt_rdata_q.head;
	assign elem_addr = AW'(team_q) * AW'(TEAM_DEPTH) + AW'(slot);

	// status to the controller
	assign sts.clear_last  = (clr_q == TW'(TEAMS - 1));
	assign sts.order_empty = (ord_count_q == '0);
	assign sts.team_full   = (tt_rdata_q.count == CW'(TEAM_DEPTH));
	assign sts.out_free    = !out_valid_q || !res_stall;

	// team table ports
	assign tt_rd    = cmd.capture || cmd.team_rd_ord;
	assign tt_raddr = cmd.capture ? team_map[team] : ord_rdata_q;
	assign tt_we    = cmd.clear_step || cmd.enq_commit || cmd.deq_commit;
	assign tt_waddr = cmd.clear_step ? clr_q : team_q;

	always_comb begin
		tt_wdata = tt_rdata_q;
		priority if (cmd.clear_step) begin
			tt_wdata = '0;
		end else if (cmd.enq_commit) begin
			tt_wdata.tail  = tail_next;
			tt_wdata.count = tt_rdata_q.count + 1'b1;
		end else if (cmd.deq_commit) begin
			tt_wdata.head  = head_next;
			tt_wdata.count = tt_rdata_q.count - 1'b1;
		end else begin
			tt_wdata = tt_rdata_q;
		end
	end

	// team table memory
	always_ff @(posedge clk) begin
		if (tt_we) begin
			tt_mem[tt_waddr] <= tt_wdata;
		end
		if (tt_rd) begin
			tt_rdata_q <= tt_mem[tt_raddr];
		end
	end

	// element memory
	always_ff @(posedge clk) begin
		if (cmd.enq_commit) begin
			elem_mem[elem_addr] <= elem_q;
		end
		if (cmd.deq_commit) begin
			elem_rdata_q <= elem_mem[elem_addr];
		end
	end

	// team order memory
	always_ff @(posedge clk) begin
		if (cmd.enq_commit && team_empty) begin
			ord_mem[ord_tail_q] <= team_q;
		end
		if (cmd.ord_rd) begin
			ord_rdata_q <= ord_mem[ord_head_q];
		end
	end

	// captured request and active team
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			team_q <= team_map[team];
			elem_q <= EB'(element);
		end else if (cmd.team_rd_ord) begin
			team_q <= ord_rdata_q;
		end
	end

	// clearing sweep counter and team order pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			ord_head_q  <= '0;
			ord_tail_q  <= '0;
			ord_count_q <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.enq_commit && team_empty) begin
				ord_tail_q  <= (ord_tail_q == TW'(TEAMS - 1)) ? '0 : ord_tail_q + 1'b1;
				ord_count_q <= ord_count_q + 1'b1;
			end else if (cmd.deq_commit && team_last) begin
				ord_head_q  <= (ord_head_q == TW'(TEAMS - 1)) ? '0 : ord_head_q + 1'b1;
				ord_count_q <= ord_count_q - 1'b1;
			end
		end
	end

	// result register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				OUT_OK: begin
					status_q      <= ST_OK;
					has_data_q    <= 1'b0;
					element_out_q <= '0;
				end
				OUT_EMPTY: begin
					status_q      <= ST_EMPTY;
					has_data_q    <= 1'b0;
					element_out_q <= '0;
				end
				OUT_FULL: begin
					status_q      <= ST_FULL;
					has_data_q    <= 1'b0;
					element_out_q <= '0;
				end
				OUT_DATA: begin
					status_q      <= ST_OK;
					has_data_q    <= 1'b1;
					element_out_q <= ELEM_W'(elem_rdata_q);
				end
			endcase
		end
	end

	assign res_valid   = out_valid_q;
	assign status      = status_q;
	assign has_data    = has_data_q;
	assign element_out = element_out_q;

endmodule

`default_nettype wire

@@ rtl/grouped_team_fifo_top.sv @@
// Team queue top level. Enqueue: team table read, then the result, with the table
// and element writes unless the team is full. Dequeue: order store read, team table
// read, element store read in turn, then the result; an empty dequeue goes straight to its result.
// One request at a time; a finished result waits in the output register.
// Reset: asynchronous; afterwards the per-team table is cleared entry by entry
// with req_stall high. Element and order stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module grouped_team_fifo_top
	import gtf_pkg::*;
#(
	parameter int TEAMS        = TEAMS_DEF,
	parameter int TEAM_DEPTH   = TEAM_DEPTH_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic              kind,
	input  wire logic [ELEM_W-1:0] element,
	input  wire logic [TEAM_W-1:0] team,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [STATUS_W-1:0]    status,
	output logic                   has_data,
	output logic [ELEM_W-1:0]      element_out
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	gtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and result register
	gtf_dp #(
		.TEAMS        (TEAMS),
		.TEAM_DEPTH   (TEAM_DEPTH),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.element     (element),
		.team        (team),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.has_data    (has_data),
		.element_out (element_out)
	);

endmodule

`default_nettype wire

@@ rtl/gtf_checker.sv @@
// gtf_checker: port-level checks of the team queue, bound to the top level.
// Uses gtf_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module gtf_checker
	import gtf_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_stall,
	input wire logic                kind,
	input wire logic [ELEM_W-1:0]   element,
	input wire logic [TEAM_W-1:0]   team,
	input wire logic                res_valid,
	input wire logic                res_stall,
	input wire logic [STATUS_W-1:0] status,
	input wire logic                has_data,
	input wire logic [ELEM_W-1:0]   element_out
);

	// one request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while another is in work");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(status) && $stable(element_out)))
		else $error("stalled result changed");

	// data only with ok status
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && has_data) |-> (status == ST_OK))
		else $error("data returned with error status");

	// no data means a zero element
	a_zero_elem: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !has_data) |-> (element_out == '0))
		else $error("element without data flag");

	// status is a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
		else $error("undefined status code");

endmodule

bind grouped_team_fifo_top gtf_checker u_gtf_checker (.*);

`default_nettype wire
